FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: rtl/bprf_pkg.sv
// ---------------------------------------------------------------------------
// bprf_pkg
// Shared constants and types of the bypassed register file.
// ---------------------------------------------------------------------------
package bprf_pkg;

  localparam int NUM_REGS  = 32;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_AW    = $clog2(NUM_REGS);

  // read ports: one array bank each
  localparam int RD_PORTS = 5;
  localparam int RP_RD    = 0;
  localparam int RP_RD_LO = 1;
  localparam int RP_RS1   = 2;
  localparam int RP_RS1_LO = 3;
  localparam int RP_RS2   = 4;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [REG_AW-1:0]    ridx_t;

  typedef struct packed {
    logic  en;
    ridx_t addr;
    word_t data;
  } wr_t;

endpackage

FILE: rtl/bprf_bank.sv
// ---------------------------------------------------------------------------
// bprf_bank
// One copy of the register array: one write port, one registered read port.
// Per-entry valid bits are cleared by reset; rd_vld_o is low when an unwritten entry is read.
// ---------------------------------------------------------------------------
module bprf_bank
  import bprf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  wr_t   wr_i,
  input  logic  rd_en_i,
  input  ridx_t rd_addr_i,
  output word_t rd_data_o,
  output logic  rd_vld_o
);

  word_t               mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q;
  word_t               rd_data_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_vld_o  = rd_vld_q;

endmodule

FILE: rtl/bypassed_register_file.sv
// ---------------------------------------------------------------------------
// bypassed_register_file
// Three-read, one-write register file with write bypass and delayed commit.
// ---------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low.
//   busy never rises, so one transaction can be issued every cycle.
//   Each transaction carries one write (write_addr 0 = no write) and the
//   read addresses; double_mode reads rd and rs1 as 64-bit register pairs.
//   Reads see, in order: zero for register 0, the write of the same
//   transaction, the write of the previous transaction, then the array.
//   The previous write commits to the array when the next transaction is
//   taken. Five banked copies of the array serve the five read addresses.
//   Results: a read passes the bank read register, then the result register;
//   result_valid_o rises as the result register loads and is high for one
//   cycle per transaction. Throughput: one transaction per cycle.
//   The receiver cannot stall; results are never held.
//   Reset: the array reads all zero (valid bits cleared), no pending write,
//   no result in flight. No clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bypassed_register_file
  import bprf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  write_addr_i,
  input  logic [31:0] write_value_i,
  input  logic [4:0]  read_rd_addr_i,
  input  logic [4:0]  read_rs1_addr_i,
  input  logic [4:0]  read_rs2_addr_i,
  input  logic        double_mode_i,
  output logic        result_valid_o,
  output logic [31:0] rd_word_o,
  output logic [31:0] rs1_word_o,
  output logic [31:0] rs2_word_o,
  output logic [63:0] rd_pair_o,
  output logic [63:0] rs1_pair_o
);

  typedef logic [ADDR_W:0]   xaddr_t;
  typedef logic [ADDR_W-1:0] addr_t;

  logic   accept;
  xaddr_t rp_addr [RD_PORTS];
  word_t  bank_data [RD_PORTS];
  logic   bank_vld [RD_PORTS];
  wr_t    commit;

  logic   s1_vld_q;
  addr_t  s1_waddr_q;
  word_t  s1_wval_q;
  addr_t  s1_prev_addr_q;
  word_t  s1_prev_val_q;
  xaddr_t s1_addr_q [RD_PORTS];
  logic   s1_dbl_q;

  word_t  rv [RD_PORTS];
  logic   res_vld_q;
  logic [31:0] rd_word_d, rs1_word_d, rs2_word_d;
  logic [63:0] rd_pair_d, rs1_pair_d;
  logic [31:0] rd_word_q, rs1_word_q, rs2_word_q;
  logic [63:0] rd_pair_q, rs1_pair_q;

  function automatic word_t resolve(xaddr_t a, word_t mem_val, logic mem_vld,
                                    addr_t ca, word_t cv, addr_t pa, word_t pv);
    word_t r;
    r = '0;
    if (a != '0 && int'(a) < NUM_REGS) begin
      if (a == {1'b0, ca}) begin
        r = cv;
      end else if (a == {1'b0, pa}) begin
        r = pv;
      end else if (mem_vld) begin
        r = mem_val;
      end
    end
    return r;
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    rp_addr[RP_RD]     = {1'b0, read_rd_addr_i};
    rp_addr[RP_RD_LO]  = {1'b0, read_rd_addr_i} + xaddr_t'(1);
    rp_addr[RP_RS1]    = {1'b0, read_rs1_addr_i};
    rp_addr[RP_RS1_LO] = {1'b0, read_rs1_addr_i} + xaddr_t'(1);
    rp_addr[RP_RS2]    = {1'b0, read_rs2_addr_i};
  end

  // previous transaction's write commits when the next one is taken
  always_comb begin
    commit.en   = accept && (s1_waddr_q != '0) && (int'(s1_waddr_q) < NUM_REGS);
    commit.addr = s1_waddr_q[REG_AW-1:0];
    commit.data = s1_wval_q;
  end

  for (genvar g = 0; g < RD_PORTS; g++) begin : g_bank
    bprf_bank u_bank (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_i      (commit),
      .rd_en_i   (accept),
      .rd_addr_i (rp_addr[g][REG_AW-1:0]),
      .rd_data_o (bank_data[g]),
      .rd_vld_o  (bank_vld[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q       <= 1'b0;
      s1_waddr_q     <= '0;
      s1_prev_addr_q <= '0;
    end else begin
      s1_vld_q <= accept;
      if (accept) begin
        s1_waddr_q     <= write_addr_i;
        s1_prev_addr_q <= s1_waddr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_wval_q     <= word_t'(write_value_i);
      s1_prev_val_q <= s1_wval_q;
      s1_dbl_q      <= double_mode_i;
      for (int i = 0; i < RD_PORTS; i++) begin
        s1_addr_q[i] <= rp_addr[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < RD_PORTS; i++) begin
      rv[i] = resolve(s1_addr_q[i], bank_data[i], bank_vld[i],
                      s1_waddr_q, s1_wval_q, s1_prev_addr_q, s1_prev_val_q);
    end
    rs2_word_d = 32'(rv[RP_RS2]);
    rd_word_d  = '0;
    rs1_word_d = '0;
    rd_pair_d  = '0;
    rs1_pair_d = '0;
    if (s1_dbl_q) begin
      rd_pair_d  = {32'(rv[RP_RD]), 32'(rv[RP_RD_LO])};
      rs1_pair_d = {32'(rv[RP_RS1]), 32'(rv[RP_RS1_LO])};
    end else begin
      rd_word_d  = 32'(rv[RP_RD]);
      rs1_word_d = 32'(rv[RP_RS1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      rd_word_q  <= rd_word_d;
      rs1_word_q <= rs1_word_d;
      rs2_word_q <= rs2_word_d;
      rd_pair_q  <= rd_pair_d;
      rs1_pair_q <= rs1_pair_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign rd_word_o      = rd_word_q;
  assign rs1_word_o     = rs1_word_q;
  assign rs2_word_o     = rs2_word_q;
  assign rd_pair_o      = rd_pair_q;
  assign rs1_pair_o     = rs1_pair_q;

  `ASSERT_CLK(a_accept_to_s1, clk_i, rst_ni, accept |=> s1_vld_q)
  `ASSERT_CLK(a_s1_to_result, clk_i, rst_ni, s1_vld_q |=> result_valid_o)
  `ASSERT_NEVER(a_commit_reg0, clk_i, rst_ni, commit.en && commit.addr == '0)
  `ASSERT_NEVER(a_mode_mix, clk_i, rst_ni,
                result_valid_o && (rd_word_o != '0 || rs1_word_o != '0) &&
                (rd_pair_o != '0 || rs1_pair_o != '0))

endmodule
